// ===== design/gcts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcts_pkg
// Shared types, constants and helpers of the grid cursor trigger sequencer.
// ----------------------------------------------------------------------------
package gcts_pkg;

	localparam int NPORTS    = 4;
	localparam int COORD_W   = 5;
	localparam int DIR_W     = 2;
	localparam int COUNT_W   = 16;
	localparam int LFSR_W    = 32;
	localparam int CELL_W    = 2;
	localparam int DATA_IN_W  = 32;
	localparam int DATA_OUT_W = 56;
	localparam int ADDR_W    = 5;
	localparam int REG_W     = 32;

	localparam int GRID_MAX_DEF = 32;

	// cell kinds
	localparam logic [CELL_W-1:0] CELL_OFF  = 2'd0;
	localparam logic [CELL_W-1:0] CELL_ON   = 2'd1;
	localparam logic [CELL_W-1:0] CELL_RAND = 2'd2;

	// directions
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

	// input opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// register indexes
	localparam logic [2:0] REG_SIZE    = 3'd0;
	localparam logic [2:0] REG_STARTX  = 3'd1;
	localparam logic [2:0] REG_STARTY  = 3'd2;
	localparam logic [2:0] REG_STARTD  = 3'd3;
	localparam logic [2:0] REG_PATCH   = 3'd4;
	localparam logic [2:0] REG_LOCKOUT = 3'd5;
	localparam logic [2:0] REG_PULSE   = 3'd6;
	localparam logic [2:0] REG_SEED    = 3'd7;

	// register reset values
	localparam logic [1:0]  RST_SIZE    = 2'd1;
	localparam logic [19:0] RST_STARTX  = 20'd0;
	localparam logic [19:0] RST_STARTY  = 20'd200768;
	localparam logic [7:0]  RST_STARTD  = 8'd0;
	localparam logic [11:0] RST_PATCH   = 12'd0;
	localparam logic [15:0] RST_LOCKOUT = 16'd48;
	localparam logic [15:0] RST_PULSE   = 16'd48;
	localparam logic [31:0] RST_SEED    = 32'd1;

	localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h80200003;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// per-lane control for one tick
	typedef struct packed {
		logic tick;
		logic shift;
		logic rst;
		logic lock_own;
		logic ok_in;
		logic clk_own;
		logic clk_edge;
		logic clk_in;
		logic turn;
	} lane_ctl_t;

	function automatic logic [COORD_W-1:0] step_dx(input logic [DIR_W-1:0] d);
		case (d)
			DIR_RIGHT: step_dx = 5'd1;
			DIR_LEFT:  step_dx = 5'h1F;
			default:   step_dx = 5'd0;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] step_dy(input logic [DIR_W-1:0] d);
		case (d)
			DIR_DOWN: step_dy = 5'd1;
			DIR_UP:   step_dy = 5'h1F;
			default:  step_dy = 5'd0;
		endcase
	endfunction

endpackage

// ===== design/gcts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcts_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/gcts_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcts_lane
// One cursor: shift, reset, lockout, clock step and turn, plus its own copy
// of the grid that is read at the cursor's new cell.
// ----------------------------------------------------------------------------
module gcts_lane
	import gcts_pkg::*;
#(
	parameter int GRID_MAX = GRID_MAX_DEF,
	parameter int IDX      = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  lane_ctl_t                      ctl,
	input  logic [COORD_W-1:0]             mask,
	input  logic [COORD_W-1:0]             start_x,
	input  logic [COORD_W-1:0]             start_y,
	input  logic [DIR_W-1:0]               start_dir,
	input  logic [COUNT_W-1:0]             lockout_ticks,
	input  logic                           wr_en,
	input  logic [2*$clog2(GRID_MAX)-1:0]  wr_addr,
	input  logic [CELL_W-1:0]              wr_data,
	input  logic                           rd_en,
	output logic [COORD_W-1:0]             cur_x,
	output logic [COORD_W-1:0]             cur_y,
	output logic [DIR_W-1:0]               cur_dir,
	output logic                           ok,
	output logic                           step,
	output logic [CELL_W-1:0]              cell_rd
);

	localparam int CW = $clog2(GRID_MAX);

	logic [COORD_W-1:0] x_q, y_q;
	logic [DIR_W-1:0]   dir_q;
	logic [COUNT_W-1:0] cnt_q;

	logic [COORD_W-1:0] x_a, y_a, x_b, y_b, x_n, y_n;
	logic [DIR_W-1:0]   d_b, d_n;
	logic [COUNT_W-1:0] cnt_c, cnt_n;
	logic [CW+COORD_W-1:0] xw, yw;
	logic [2*CW-1:0]    raddr;

	always_comb begin
		// sideways shift: x -= dy, y += dx
		if (ctl.shift) begin
			x_a = (x_q - step_dy(dir_q)) & mask;
			y_a = (y_q + step_dx(dir_q)) & mask;
		end else begin
			x_a = x_q;
			y_a = y_q;
		end
		x_b = ctl.rst ? start_x : x_a;
		y_b = ctl.rst ? start_y : y_a;
		d_b = ctl.rst ? start_dir : dir_q;

		if (ctl.lock_own) begin
			cnt_c = ctl.rst ? '0 : cnt_q;
			cnt_n = (cnt_c == COUNT_MAX) ? cnt_c : cnt_c + 16'd1;
			ok    = cnt_n >= lockout_ticks;
		end else begin
			cnt_c = cnt_q;
			cnt_n = cnt_q;
			ok    = ctl.ok_in;
		end

		step = ctl.clk_own ? (ok && ctl.clk_edge) : ctl.clk_in;
		if (step) begin
			x_n = (x_b + step_dx(d_b)) & mask;
			y_n = (y_b + step_dy(d_b)) & mask;
		end else begin
			x_n = x_b;
			y_n = y_b;
		end
		d_n = ctl.turn ? d_b + 2'd1 : d_b;

		xw    = {{CW{1'b0}}, x_n};
		yw    = {{CW{1'b0}}, y_n};
		raddr = {xw[CW-1:0], yw[CW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= RST_STARTX[IDX*COORD_W +: COORD_W];
			y_q   <= RST_STARTY[IDX*COORD_W +: COORD_W];
			dir_q <= RST_STARTD[IDX*DIR_W +: DIR_W];
			cnt_q <= COUNT_MAX;
		end else if (en && ctl.tick) begin
			x_q   <= x_n;
			y_q   <= y_n;
			dir_q <= d_n;
			cnt_q <= cnt_n;
		end
	end

	gcts_ram #(
		.WIDTH (CELL_W),
		.DEPTH (GRID_MAX * GRID_MAX)
	) u_grid (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (cell_rd)
	);

	assign cur_x   = x_q;
	assign cur_y   = y_q;
	assign cur_dir = dir_q;

endmodule

// ===== design/gcts_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcts_merge
// Combines the lanes' landings: random bits in port order, pulse timers and
// the gate word.
// ----------------------------------------------------------------------------
module gcts_merge
	import gcts_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           tick,
	input  logic [NPORTS-1:0]              step,
	input  logic [NPORTS-1:0][CELL_W-1:0]  cell_rd,
	input  logic [COUNT_W-1:0]             pulse_ticks,
	input  logic                           seed_load,
	input  logic [LFSR_W-1:0]              seed,
	output logic [NPORTS-1:0]              gates
);

	logic [LFSR_W-1:0]               lfsr_q, lfsr_n;
	logic [NPORTS-1:0][COUNT_W-1:0]  pulse_q, pulse_n;
	logic [NPORTS-1:0]               last_q, gates_n;

	always_comb begin
		logic [COUNT_W-1:0] pl;
		logic               b;
		logic               fire;
		lfsr_n = lfsr_q;
		for (int i = 0; i < NPORTS; i++) begin
			pl   = pulse_q[i];
			b    = 1'b0;
			fire = 1'b0;
			if (step[i]) begin
				if (cell_rd[i] == CELL_RAND) begin
					b      = lfsr_n[0];
					lfsr_n = b ? ((lfsr_n >> 1) ^ LFSR_MASK) : (lfsr_n >> 1);
				end
				fire = (cell_rd[i] == CELL_ON) || (cell_rd[i] == CELL_RAND && b);
			end
			if (fire && pulse_ticks > pl) begin
				pl = pulse_ticks;
			end
			gates_n[i] = pl != '0;
			pulse_n[i] = (pl != '0) ? pl - 16'd1 : pl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q  <= RST_SEED;
			pulse_q <= '0;
			last_q  <= '0;
		end else begin
			if (seed_load) begin
				lfsr_q <= (seed == '0) ? {{(LFSR_W-1){1'b0}}, 1'b1} : seed;
			end else if (en && tick) begin
				lfsr_q <= lfsr_n;
			end
			if (en && tick) begin
				pulse_q <= pulse_n;
				last_q  <= gates_n;
			end
		end
	end

	// a grid write repeats the last tick's gates
	assign gates = tick ? gates_n : last_q;

endmodule

// ===== design/grid_cursor_trigger_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cursor_trigger_sequencer
// Four cursors on a square grid of off/on/random cells, firing gate pulses.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per audio tick (s_tuser = 0) carrying qualified
// clock, reset and turn edges per port plus the shared shift edge, or a grid
// cell write (s_tuser = 1). Output stream m_*: one word per input word with
// the gates and the cursor positions and directions after that word.
// APB port: eight registers at 0x00..0x1C; the user must write them only
// while idle, the block does not enforce it. Throughput: one word per cycle
// unless the output stalls. An accepted word passes stage 1 and the output
// register; the cursor update and the per-lane grid copy read run in the
// accept cycle, so the gate logic sees the cell in the cycle after.
// Stall: the output register holds its word; one more input word is taken
// into the first stage, then s_tready drops until the output is taken.
// Reset: registers and cursors take their reset values, then a clearing pass
// over all GRID_MAX*GRID_MAX cells (1024 by default) zeroes the grid copies;
// no input word is accepted during it, configuration writes are.
// ----------------------------------------------------------------------------
module grid_cursor_trigger_sequencer
	import gcts_pkg::*;
#(
	parameter int GRID_MAX = GRID_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// clock_edges[3:0], reset_edges[7:4], turn_edges[11:8], shift_edge[12],
	// cell_col[17:13], cell_row[22:18], cell_kind[24:23], zero fill
	input  logic [DATA_IN_W-1:0]  s_tdata,
	// opcode[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// gates[3:0], cursor_x_packed[23:4], cursor_y_packed[43:24],
	// cursor_dir_packed[51:44], zero fill
	output logic [DATA_OUT_W-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [REG_W-1:0]      pwdata,
	output logic [REG_W-1:0]      prdata,
	output logic                  pready
);

	localparam int CW = $clog2(GRID_MAX);
	localparam int AW = 2 * CW;

	// configuration
	logic [1:0]  size_code_q;
	logic [19:0] start_x_q, start_y_q;
	logic [7:0]  start_dir_q;
	logic [11:0] patch_q;
	logic [15:0] lockout_q, pulse_ticks_q;
	logic [31:0] seed_q;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_code_q   <= RST_SIZE;
			start_x_q     <= RST_STARTX;
			start_y_q     <= RST_STARTY;
			start_dir_q   <= RST_STARTD;
			patch_q       <= RST_PATCH;
			lockout_q     <= RST_LOCKOUT;
			pulse_ticks_q <= RST_PULSE;
			seed_q        <= RST_SEED;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SIZE:    size_code_q   <= pwdata[1:0];
				REG_STARTX:  start_x_q     <= pwdata[19:0];
				REG_STARTY:  start_y_q     <= pwdata[19:0];
				REG_STARTD:  start_dir_q   <= pwdata[7:0];
				REG_PATCH:   patch_q       <= pwdata[11:0];
				REG_LOCKOUT: lockout_q     <= pwdata[15:0];
				REG_PULSE:   pulse_ticks_q <= pwdata[15:0];
				REG_SEED:    seed_q        <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SIZE:    prdata = {30'd0, size_code_q};
			REG_STARTX:  prdata = {12'd0, start_x_q};
			REG_STARTY:  prdata = {12'd0, start_y_q};
			REG_STARTD:  prdata = {24'd0, start_dir_q};
			REG_PATCH:   prdata = {20'd0, patch_q};
			REG_LOCKOUT: prdata = {16'd0, lockout_q};
			REG_PULSE:   prdata = {16'd0, pulse_ticks_q};
			REG_SEED:    prdata = seed_q;
			default:     prdata = '0;
		endcase
	end

	// side mask: min(4 << size_code, GRID_MAX) - 1
	logic [6:0]         side, side_lim;
	logic [COORD_W-1:0] mask;

	always_comb begin
		side     = 7'd4 << size_code_q;
		side_lim = (side > 7'(GRID_MAX)) ? 7'(GRID_MAX) : side;
		mask     = COORD_W'(side_lim - 7'd1);
	end

	// grid clearing pass after reset
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == {AW{1'b1}}) begin
				clr_q <= 1'b0;
			end
		end
	end

	// handshake and pipeline control
	logic accept, s1_en, adv;
	logic valid_s1, tick_s1;
	logic [NPORTS-1:0] step_s1;
	logic out_valid_q;
	logic [DATA_OUT_W-1:0] out_data_q;

	assign adv      = !out_valid_q || m_tready;
	assign s1_en    = !valid_s1 || adv;
	assign s_tready = s1_en && !clr_q;
	assign accept   = s_tvalid && s_tready;

	// input fields
	logic [NPORTS-1:0] clk_e, rst_e, turn_e;
	logic              shift_e, is_tick;
	logic [COORD_W-1:0] col, row;
	logic [CELL_W-1:0]  kind;
	logic [CW+COORD_W-1:0] colw, roww;

	assign clk_e   = s_tdata[3:0];
	assign rst_e   = s_tdata[7:4];
	assign turn_e  = s_tdata[11:8];
	assign shift_e = s_tdata[12];
	assign col     = s_tdata[17:13];
	assign row     = s_tdata[22:18];
	assign kind    = s_tdata[24:23];
	assign is_tick = (s_tuser == OP_TICK);
	assign colw    = {{CW{1'b0}}, col};
	assign roww    = {{CW{1'b0}}, row};

	// grid write, broadcast to every lane copy
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [CELL_W-1:0] wr_data;

	always_comb begin
		wr_en   = clr_q || (accept && s_tuser == OP_WRITE);
		wr_addr = clr_q ? clr_cnt_q : {colw[CW-1:0], roww[CW-1:0]};
		if (clr_q || kind == 2'd3) begin
			wr_data = CELL_OFF;
		end else begin
			wr_data = kind;
		end
	end

	// lanes
	lane_ctl_t [NPORTS-1:0]             ctl;
	logic [NPORTS-1:0]                  ok, step;
	logic [NPORTS-1:0][COORD_W-1:0]     cur_x, cur_y;
	logic [NPORTS-1:0][DIR_W-1:0]       cur_dir;
	logic [NPORTS-1:0][CELL_W-1:0]      cell_rd;

	// unpatched ports follow port 0
	always_comb begin
		for (int i = 0; i < NPORTS; i++) begin
			ctl[i].tick     = is_tick;
			ctl[i].shift    = shift_e;
			ctl[i].clk_edge = clk_e[i];
			if (i == 0) begin
				ctl[i].rst      = rst_e[0];
				ctl[i].lock_own = 1'b1;
				ctl[i].ok_in    = 1'b0;
				ctl[i].clk_own  = 1'b1;
				ctl[i].clk_in   = 1'b0;
				ctl[i].turn     = turn_e[0];
			end else begin
				ctl[i].rst      = patch_q[NPORTS+i] ? rst_e[i] : rst_e[0];
				ctl[i].lock_own = patch_q[NPORTS+i];
				ctl[i].ok_in    = ok[0];
				ctl[i].clk_own  = patch_q[i];
				ctl[i].clk_in   = step[0];
				ctl[i].turn     = patch_q[2*NPORTS+i] ? turn_e[i] : turn_e[0];
			end
		end
	end

	for (genvar g = 0; g < NPORTS; g++) begin : g_lane
		gcts_lane #(
			.GRID_MAX (GRID_MAX),
			.IDX      (g)
		) u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.en            (accept),
			.ctl           (ctl[g]),
			.mask          (mask),
			.start_x       (start_x_q[g*COORD_W +: COORD_W]),
			.start_y       (start_y_q[g*COORD_W +: COORD_W]),
			.start_dir     (start_dir_q[g*DIR_W +: DIR_W]),
			.lockout_ticks (lockout_q),
			.wr_en         (wr_en),
			.wr_addr       (wr_addr),
			.wr_data       (wr_data),
			.rd_en         (s1_en),
			.cur_x         (cur_x[g]),
			.cur_y         (cur_y[g]),
			.cur_dir       (cur_dir[g]),
			.ok            (ok[g]),
			.step          (step[g]),
			.cell_rd       (cell_rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			tick_s1  <= 1'b0;
			step_s1  <= '0;
		end else if (s1_en) begin
			valid_s1 <= accept;
			tick_s1  <= accept && is_tick;
			step_s1  <= (accept && is_tick) ? step : '0;
		end
	end

	// merge stage
	logic [NPORTS-1:0] gates;

	gcts_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv && valid_s1),
		.tick        (tick_s1),
		.step        (step_s1),
		.cell_rd     (cell_rd),
		.pulse_ticks (pulse_ticks_q),
		.seed_load   (cfg_wr && cfg_idx == REG_SEED),
		.seed        (pwdata),
		.gates       (gates)
	);

	// output register; lane cursor registers still hold the stage-1 word here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_data_q <= {4'd0, cur_dir, cur_y, cur_x, gates};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== test/tb_grid_cursor_trigger_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_cursor_trigger_sequencer
// Self-checking bench for the grid cursor trigger sequencer. A queue of
// stream words (ticks and grid cell writes) feeds a clocked driver; a
// behavioral copy of the cursors, lockouts, pulses, grid and LFSR predicts
// each output word, and a clocked monitor compares gates and cursor fields.
// Both stream sides idle in random bursts, except in the last phase. Register
// settings change between phases while the block is idle, extremes included.
// ----------------------------------------------------------------------------
module tb_grid_cursor_trigger_sequencer;
	import gcts_pkg::*;

	typedef struct packed {
		logic       op;
		logic [3:0] clk_e;
		logic [3:0] rst_e;
		logic [3:0] turn_e;
		logic       shift;
		logic [4:0] col;
		logic [4:0] row;
		logic [1:0] kind;
	} seq_item_t;

	typedef struct packed {
		logic [3:0]  gates;
		logic [19:0] xs;
		logic [19:0] ys;
		logic [7:0]  dirs;
	} seq_view_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DATA_IN_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_OUT_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [REG_W-1:0]      pwdata = '0;
	logic [REG_W-1:0]      prdata;
	logic                  pready;

	grid_cursor_trigger_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies
	logic [1:0]  cfg_size;
	logic [19:0] cfg_sx, cfg_sy;
	logic [7:0]  cfg_sd;
	logic [11:0] cfg_patch;
	logic [15:0] cfg_lock, cfg_pulse;

	// sequencer state copy
	logic [4:0]  cur_x [NPORTS];
	logic [4:0]  cur_y [NPORTS];
	logic [1:0]  cur_dir [NPORTS];
	logic [15:0] lock_cnt [NPORTS];
	logic [15:0] pulse_cnt [NPORTS];
	logic [1:0]  grid_cells [1024];
	logic [31:0] lfsr;
	logic [3:0]  last_gates;

	seq_item_t pending_words [$];
	seq_view_t cursor_words_due [$];
	seq_item_t held_item;
	seq_view_t due;
	int        src_gap = 0;
	int        snk_gap = 0;
	bit        steady = 1'b0;
	int        errs = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errs++;
	endtask

	function automatic void load_start(input int i);
		cur_x[i]   = cfg_sx[5*i +: 5];
		cur_y[i]   = cfg_sy[5*i +: 5];
		cur_dir[i] = cfg_sd[2*i +: 2];
	endfunction

	function automatic void seq_reset_state();
		cfg_size  = RST_SIZE;
		cfg_sx    = RST_STARTX;
		cfg_sy    = RST_STARTY;
		cfg_sd    = RST_STARTD;
		cfg_patch = RST_PATCH;
		cfg_lock  = RST_LOCKOUT;
		cfg_pulse = RST_PULSE;
		for (int i = 0; i < NPORTS; i++) begin
			load_start(i);
			lock_cnt[i]  = COUNT_MAX;
			pulse_cnt[i] = '0;
		end
		for (int c = 0; c < 1024; c++)
			grid_cells[c] = CELL_OFF;
		lfsr       = RST_SEED;
		last_gates = '0;
	endfunction

	function automatic void seq_set_reg(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			REG_SIZE:    cfg_size  = val[1:0];
			REG_STARTX:  cfg_sx    = val[19:0];
			REG_STARTY:  cfg_sy    = val[19:0];
			REG_STARTD:  cfg_sd    = val[7:0];
			REG_PATCH:   cfg_patch = val[11:0];
			REG_LOCKOUT: cfg_lock  = val[15:0];
			REG_PULSE:   cfg_pulse = val[15:0];
			REG_SEED:    lfsr      = (val == 32'd0) ? 32'd1 : val;
			default: ;
		endcase
	endfunction

	function automatic logic lfsr_draw();
		logic b;
		b = lfsr[0];
		lfsr = lfsr >> 1;
		if (b)
			lfsr = lfsr ^ LFSR_MASK;
		return b;
	endfunction

	// one stream word through the sequencer; returns the output word it causes
	function automatic seq_view_t seq_advance(input seq_item_t it);
		seq_view_t  v;
		logic [4:0] m;
		logic       r0, ok0, c0, t0, r, ok, c, t, fire;
		logic [3:0] g;
		logic [1:0] here;
		m = 5'((6'd4 << cfg_size) - 6'd1);
		r0 = 1'b0; ok0 = 1'b0; c0 = 1'b0; t0 = 1'b0; g = '0;
		if (it.op == OP_WRITE) begin
			grid_cells[{it.col, it.row}] = (it.kind == 2'd3) ? CELL_OFF : it.kind;
		end else begin
			if (it.shift) begin
				// sideways: x -= dy, y += dx
				for (int i = 0; i < NPORTS; i++) begin
					case (cur_dir[i])
						DIR_RIGHT: cur_y[i] = cur_y[i] + 5'd1;
						DIR_DOWN:  cur_x[i] = cur_x[i] - 5'd1;
						DIR_LEFT:  cur_y[i] = cur_y[i] - 5'd1;
						default:   cur_x[i] = cur_x[i] + 5'd1;
					endcase
					cur_x[i] = cur_x[i] & m;
					cur_y[i] = cur_y[i] & m;
				end
			end
			for (int i = 0; i < NPORTS; i++) begin
				r = (i == 0 || cfg_patch[4+i]) ? it.rst_e[i] : r0;
				if (i == 0) r0 = r;
				if (r) load_start(i);

				if (i == 0 || cfg_patch[4+i]) begin
					if (r) lock_cnt[i] = '0;
					if (lock_cnt[i] != COUNT_MAX) lock_cnt[i] = lock_cnt[i] + 16'd1;
					ok = lock_cnt[i] >= cfg_lock;
				end else begin
					ok = ok0;
				end
				if (i == 0) ok0 = ok;

				c = (i == 0 || cfg_patch[i]) ? (ok && it.clk_e[i]) : c0;
				if (i == 0) c0 = c;
				if (c) begin
					case (cur_dir[i])
						DIR_RIGHT: cur_x[i] = cur_x[i] + 5'd1;
						DIR_DOWN:  cur_y[i] = cur_y[i] + 5'd1;
						DIR_LEFT:  cur_x[i] = cur_x[i] - 5'd1;
						default:   cur_y[i] = cur_y[i] - 5'd1;
					endcase
					cur_x[i] = cur_x[i] & m;
					cur_y[i] = cur_y[i] & m;
				end

				t = (i == 0 || cfg_patch[8+i]) ? it.turn_e[i] : t0;
				if (i == 0) t0 = t;
				if (t) cur_dir[i] = cur_dir[i] + 2'd1;

				if (c) begin
					here = grid_cells[{cur_x[i], cur_y[i]}];
					fire = 1'b0;
					if (here == CELL_ON)
						fire = 1'b1;
					else if (here == CELL_RAND)
						fire = lfsr_draw();
					if (fire && cfg_pulse > pulse_cnt[i])
						pulse_cnt[i] = cfg_pulse;
				end

				if (pulse_cnt[i] != 16'd0) begin
					pulse_cnt[i] = pulse_cnt[i] - 16'd1;
					g[i] = 1'b1;
				end
			end
			last_gates = g;
		end
		v.gates = last_gates;
		for (int i = 0; i < NPORTS; i++) begin
			v.xs[5*i +: 5]   = cur_x[i];
			v.ys[5*i +: 5]   = cur_y[i];
			v.dirs[2*i +: 2] = cur_dir[i];
		end
		return v;
	endfunction

	// stream driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			cursor_words_due.push_back(seq_advance(held_item));
		if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (!steady && pending_words.size() != 0 && $urandom_range(0, 9) == 0) begin
				src_gap = $urandom_range(1, 19) - 1;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				held_item = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= held_item.op;
				s_tdata  <= {7'd0, held_item.kind, held_item.row, held_item.col,
					held_item.shift, held_item.turn_e, held_item.rst_e, held_item.clk_e};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output monitor and sink stalls
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (cursor_words_due.size() == 0) begin
				report_mismatch("word with nothing due", m_tdata[31:0], 32'd0);
			end else begin
				due = cursor_words_due.pop_front();
				if (m_tdata[3:0] != due.gates)
					report_mismatch("gates", 32'(m_tdata[3:0]), 32'(due.gates));
				if (m_tdata[23:4] != due.xs)
					report_mismatch("cursor_x", 32'(m_tdata[23:4]), 32'(due.xs));
				if (m_tdata[43:24] != due.ys)
					report_mismatch("cursor_y", 32'(m_tdata[43:24]), 32'(due.ys));
				if (m_tdata[51:44] != due.dirs)
					report_mismatch("cursor_dir", 32'(m_tdata[51:44]), 32'(due.dirs));
			end
		end
		if (snk_gap > 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 9) == 0) begin
			snk_gap = $urandom_range(1, 19) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		seq_set_reg(idx, val);
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || s_tvalid || cursor_words_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic seq_item_t tick_of(input logic [3:0] ce, input logic [3:0] re,
			input logic [3:0] te, input logic sh);
		seq_item_t it;
		it = {1'b0, ce, re, te, sh, 12'd0};
		it.op = OP_TICK;
		return it;
	endfunction

	function automatic seq_item_t cell_of(input logic [4:0] col, input logic [4:0] row,
			input logic [1:0] kind);
		seq_item_t it;
		it = '0;
		it.op = OP_WRITE;
		it.col = col;
		it.row = row;
		it.kind = kind;
		return it;
	endfunction

	task automatic queue_random(input int n);
		seq_item_t it;
		int        side, pick;
		side = 4 << cfg_size;
		for (int k = 0; k < n; k++) begin
			it = seq_item_t'($urandom);
			pick = $urandom_range(0, 19);
			if (pick < 5) begin
				// cell write, mostly inside the current side
				it.op = OP_WRITE;
				if ($urandom_range(0, 7) != 0) begin
					it.col = 5'($urandom_range(0, side - 1));
					it.row = 5'($urandom_range(0, side - 1));
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3: it.kind = CELL_ON;
					4, 5, 6:    it.kind = CELL_RAND;
					7, 8:       it.kind = CELL_OFF;
					default:    it.kind = 2'd3;
				endcase
			end else if (pick < 19) begin
				it.op = OP_TICK;
				for (int b = 0; b < 4; b++) begin
					it.clk_e[b]  = 1'($urandom_range(0, 1));
					it.rst_e[b]  = ($urandom_range(0, 24) == 0);
					it.turn_e[b] = ($urandom_range(0, 6) == 0);
				end
				it.shift = ($urandom_range(0, 9) == 0);
			end
			pending_words.push_back(it);
		end
	endtask

	task automatic random_settings();
		reg_write(REG_SIZE, $urandom_range(0, 3));
		reg_write(REG_STARTX, $urandom & 32'hFFFFF);
		reg_write(REG_STARTY, $urandom & 32'hFFFFF);
		reg_write(REG_STARTD, $urandom & 32'hFF);
		reg_write(REG_PATCH, $urandom & 32'hFFF);
		reg_write(REG_LOCKOUT, $urandom_range(0, 12));
		reg_write(REG_PULSE, $urandom_range(0, 24));
		reg_write(REG_SEED, $urandom);
	endtask

	initial begin
		seq_reset_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: side 8, cursors start on rows 0, 2, 4 and 6
		pending_words.push_back(cell_of(5'd1, 5'd0, CELL_ON));
		pending_words.push_back(cell_of(5'd2, 5'd0, CELL_RAND));
		pending_words.push_back(cell_of(5'd3, 5'd0, 2'd3));
		pending_words.push_back(cell_of(5'd31, 5'd31, CELL_ON));
		pending_words.push_back(cell_of(5'd4, 5'd0, CELL_RAND));
		for (int k = 0; k < 8; k++)
			pending_words.push_back(tick_of(4'h1, 4'h0, 4'h0, 1'b0));
		pending_words.push_back(tick_of(4'h0, 4'h0, 4'hF, 1'b0));
		pending_words.push_back(tick_of(4'h0, 4'h0, 4'h0, 1'b1));
		// reset with a clock in the same tick: lockout holds the clock off
		pending_words.push_back(tick_of(4'h1, 4'h1, 4'h0, 1'b0));
		pending_words.push_back(tick_of(4'h1, 4'h0, 4'h0, 1'b0));
		pending_words.push_back(tick_of(4'hF, 4'hF, 4'hF, 1'b1));
		pending_words.push_back(tick_of(4'h0, 4'h0, 4'h0, 1'b0));
		pending_words.push_back('1);
		pending_words.push_back(tick_of(4'hF, 4'h0, 4'h0, 1'b0));
		drain();

		// upper extremes, zero lockout, zero seed
		reg_write(REG_SIZE, 32'd3);
		reg_write(REG_STARTX, 32'hFFFFF);
		reg_write(REG_STARTY, 32'hFFFFF);
		reg_write(REG_STARTD, 32'hFF);
		reg_write(REG_PATCH, 32'hFFF);
		reg_write(REG_LOCKOUT, 32'd0);
		reg_write(REG_PULSE, 32'hFFFF);
		reg_write(REG_SEED, 32'd0);
		pending_words.push_back(tick_of(4'h0, 4'hF, 4'h0, 1'b0));
		queue_random(115);
		drain();

		// lower extremes: smallest grid, zero pulse, longest lockout
		reg_write(REG_SIZE, 32'd0);
		reg_write(REG_STARTX, 32'd0);
		reg_write(REG_STARTY, 32'd0);
		reg_write(REG_STARTD, 32'd0);
		reg_write(REG_PATCH, 32'd0);
		reg_write(REG_LOCKOUT, 32'hFFFF);
		reg_write(REG_PULSE, 32'd0);
		reg_write(REG_SEED, 32'hFFFFFFFF);
		queue_random(115);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 3)
				steady = 1'b1;
			random_settings();
			queue_random(115);
			drain();
		end

		repeat (10) @(posedge clk);
		if (errs == 0)
			$display("tb_grid_cursor_trigger_sequencer: clean");
		else
			$display("tb_grid_cursor_trigger_sequencer: errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb_grid_cursor_trigger_sequencer: errors");
		$finish;
	end

endmodule

// ===== grid_cursor_trigger_sequencer.f =====
design/gcts_pkg.sv
design/gcts_ram.sv
design/gcts_lane.sv
design/gcts_merge.sv
design/grid_cursor_trigger_sequencer.sv
test/tb_grid_cursor_trigger_sequencer.sv
